/* src/signed_divide_with_overflow_unit_assert.svh */
// assertion macros for the signed divide unit checker
// depends on a clk and arst_n in the scope of use
`ifndef SIGNED_DIVIDE_WITH_OVERFLOW_UNIT_ASSERT_SVH
`define SIGNED_DIVIDE_WITH_OVERFLOW_UNIT_ASSERT_SVH

// clocked assertion, off during reset
`define SDIV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same, with an antecedent that implies the property in the next cycle
`define SDIV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sdiv_pkg.sv */
// shared types and constants for the signed divide unit
// no dependencies
package sdiv_pkg;

	localparam int unsigned QBITS = 32;
	localparam int unsigned STEPS_PER_STAGE_DEF = 4;

	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_DWORD = 2'd2,
		MODE_DWORD_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	// work carried down the pipeline
	typedef struct packed {
		logic [QBITS-1:0] rem;
		logic [QBITS-1:0] quo;
		logic [QBITS-1:0] dmag;
		logic nn;
		logic qn;
		logic [1:0] mode;
		logic dz;
		logic ovf;
	} work_t;

endpackage

/* src/sdiv_pre.sv */
// first stage: sign extension, magnitudes, zero and early overflow check
// depends on sdiv_pkg
module sdiv_pre (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [1:0] mode,
	input  logic [31:0] dividend_high,
	input  logic [31:0] dividend_low,
	input  logic [31:0] divisor,
	output logic valid_s1,
	output sdiv_pkg::work_t work_s1
);
	logic [63:0] dend;
	logic [63:0] nmag;
	logic [31:0] dsor;
	logic [31:0] dmag;
	sdiv_pkg::work_t w;

	always_comb begin
		case (mode)
			sdiv_pkg::MODE_BYTE: begin
				dend = {{48{dividend_low[15]}}, dividend_low[15:0]};
				dsor = {{24{divisor[7]}}, divisor[7:0]};
			end
			sdiv_pkg::MODE_WORD: begin
				dend = {{32{dividend_high[15]}}, dividend_high[15:0], dividend_low[15:0]};
				dsor = {{16{divisor[15]}}, divisor[15:0]};
			end
			default: begin
				dend = {dividend_high, dividend_low};
				dsor = divisor;
			end
		endcase
		nmag = dend[63] ? (64'd0 - dend) : dend;
		dmag = dsor[31] ? (32'd0 - dsor) : dsor;
		w.rem = nmag[63:32];
		w.quo = nmag[31:0];
		w.dmag = dmag;
		w.nn = dend[63];
		w.qn = dend[63] ^ dsor[31];
		w.mode = mode;
		w.dz = (dmag == 32'd0);
		// quotient needs more than 32 bits
		w.ovf = (nmag[63:32] >= dmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= w;
		end
	end
endmodule

/* src/sdiv_step.sv */
// one pipeline stage of restoring division steps
// depends on sdiv_pkg
module sdiv_step #(
	parameter int unsigned STEPS = sdiv_pkg::STEPS_PER_STAGE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sdiv_pkg::work_t in_work,
	output logic valid_sx,
	output sdiv_pkg::work_t work_sx
);
	sdiv_pkg::work_t w;
	logic [32:0] t;

	always_comb begin
		w = in_work;
		t = '0;
		for (int i = 0; i < STEPS; i++) begin
			t = {w.rem, w.quo[31]};
			if (t >= {1'b0, w.dmag}) begin
				t = t - {1'b0, w.dmag};
				w.quo = {w.quo[30:0], 1'b1};
			end else begin
				w.quo = {w.quo[30:0], 1'b0};
			end
			w.rem = t[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sx <= 1'b0;
		end else if (en) begin
			valid_sx <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_sx <= w;
		end
	end
endmodule

/* src/sdiv_post.sv */
// last stage: range check, sign fix-up, masking, output register
// depends on sdiv_pkg
module sdiv_post (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sdiv_pkg::work_t in_work,
	output logic valid_sz,
	output logic [1:0] status_sz,
	output logic [31:0] quotient_sz,
	output logic [31:0] remainder_sz
);
	logic [32:0] limit;
	logic [31:0] wmask;
	logic [31:0] q;
	logic [31:0] r;
	logic ovf;
	sdiv_pkg::status_t st;

	always_comb begin
		case (in_work.mode)
			sdiv_pkg::MODE_BYTE: begin
				limit = 33'h80;
				wmask = 32'h0000_00ff;
			end
			sdiv_pkg::MODE_WORD: begin
				limit = 33'h8000;
				wmask = 32'h0000_ffff;
			end
			default: begin
				limit = 33'h8000_0000;
				wmask = 32'hffff_ffff;
			end
		endcase
		ovf = in_work.ovf | (in_work.qn ? ({1'b0, in_work.quo} > limit)
			: ({1'b0, in_work.quo} >= limit));
		q = (in_work.qn ? (32'd0 - in_work.quo) : in_work.quo) & wmask;
		r = (in_work.nn ? (32'd0 - in_work.rem) : in_work.rem) & wmask;
		if (in_work.dz) begin
			st = sdiv_pkg::ST_DIVZERO;
		end else if (ovf) begin
			st = sdiv_pkg::ST_OVERFLOW;
		end else begin
			st = sdiv_pkg::ST_OK;
		end
		if (st != sdiv_pkg::ST_OK) begin
			q = '0;
			r = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sz <= 1'b0;
		end else if (en) begin
			valid_sz <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_sz <= st;
			quotient_sz <= q;
			remainder_sz <= r;
		end
	end
endmodule

/* src/signed_divide_with_overflow_unit.sv */
// top level of the pipelined x86 signed divide unit
// depends on sdiv_pkg, sdiv_pre, sdiv_step, sdiv_post
//
// signed divide of AX by an 8-bit, DX:AX by a 16-bit or EDX:EAX by a 32-bit
// divisor, one word per cycle while not stalled at the output, fully pipelined.
// the first stage sign-extends the operands, takes magnitudes, flags a zero
// divisor and flags overflow when the upper half of the dividend magnitude is
// not below the divisor magnitude (quotient would need more than 32 bits).
// then 32 restoring division steps run, STEPS_PER_STAGE per register stage,
// and a final stage checks the signed range for the operand size, applies
// signs and masks the result. throughput is one word per cycle unless the
// output stalls. every stage holds its word under backpressure and a stage
// accepts as soon as it is empty or moving on, so bubbles are squeezed out
// while a result waits at the output.
module signed_divide_with_overflow_unit #(
	parameter int unsigned STEPS_PER_STAGE = sdiv_pkg::STEPS_PER_STAGE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] mode,
	input  logic [31:0] dividend_high,
	input  logic [31:0] dividend_low,
	input  logic [31:0] divisor,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	// number of division stages between the first and last stage
	localparam int unsigned NSTG = sdiv_pkg::QBITS / STEPS_PER_STAGE;

	// index 0 is the first stage, 1..NSTG the division stages
	logic valid_s [NSTG+1];
	sdiv_pkg::work_t work_s [NSTG+1];
	logic en_s [NSTG+2];

	// a stage moves when it is empty or its successor moves
	assign en_s[NSTG+1] = !out_valid || out_ready;
	genvar g;
	generate
		for (g = 0; g <= NSTG; g++) begin : g_en
			assign en_s[g] = !valid_s[g] || en_s[g+1];
		end
	endgenerate
	assign in_ready = en_s[0];

	sdiv_pre u_pre (
		.clk(clk),
		.arst_n(arst_n),
		.en(en_s[0]),
		.in_valid(in_valid),
		.mode(mode),
		.dividend_high(dividend_high),
		.dividend_low(dividend_low),
		.divisor(divisor),
		.valid_s1(valid_s[0]),
		.work_s1(work_s[0])
	);

	generate
		for (g = 1; g <= NSTG; g++) begin : g_step
			sdiv_step #(.STEPS(STEPS_PER_STAGE)) u_step (
				.clk(clk),
				.arst_n(arst_n),
				.en(en_s[g]),
				.in_valid(valid_s[g-1]),
				.in_work(work_s[g-1]),
				.valid_sx(valid_s[g]),
				.work_sx(work_s[g])
			);
		end
	endgenerate

	sdiv_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en_s[NSTG+1]),
		.in_valid(valid_s[NSTG]),
		.in_work(work_s[NSTG]),
		.valid_sz(out_valid),
		.status_sz(status),
		.quotient_sz(quotient),
		.remainder_sz(remainder)
	);
endmodule

/* src/sdiv_checker.sv */
// port-level checker for the signed divide unit, bound to the top level
// depends on sdiv_pkg and signed_divide_with_overflow_unit_assert.svh
`include "signed_divide_with_overflow_unit_assert.svh"

module sdiv_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [1:0] status,
	input  logic [31:0] quotient,
	input  logic [31:0] remainder
);
	// stalled result holds
	`SDIV_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(quotient) && $stable(remainder) && $stable(status), "stalled result changed")
	// divide error carries zero fields
	`SDIV_ASSERT(a_dz_zero, !(out_valid && status == sdiv_pkg::ST_DIVZERO) || (quotient == 32'd0 && remainder == 32'd0), "divide error with nonzero fields")
	// overflow carries zero fields
	`SDIV_ASSERT(a_ovf_zero, !(out_valid && status == sdiv_pkg::ST_OVERFLOW) || (quotient == 32'd0 && remainder == 32'd0), "overflow with nonzero fields")
	// unused status never shows
	`SDIV_ASSERT(a_status, !out_valid || status != sdiv_pkg::ST_UNUSED, "unused status code")
endmodule

bind signed_divide_with_overflow_unit sdiv_checker u_sdiv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.quotient(quotient),
	.remainder(remainder)
);

/* sim/signed_divide_with_overflow_unit_tb.sv */
// self-checking testbench for the pipelined x86 signed divide unit
// depends on sdiv_pkg and signed_divide_with_overflow_unit
`timescale 1ns / 100ps

module signed_divide_with_overflow_unit_tb;

	typedef struct {
		logic [1:0] mode;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] dv;
	} div_op_t;

	typedef struct {
		sdiv_pkg::status_t st;
		logic [31:0] q;
		logic [31:0] r;
	} div_res_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic [31:0] dividend_high;
	logic [31:0] dividend_low;
	logic [31:0] divisor;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [31:0] quotient;
	logic [31:0] remainder;

	div_op_t pending_ops[$];
	div_res_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	// sender pause request: hold until every result is in
	bit drain_req = 0;
	// receiver long hold-off, counted down in the monitor
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;

	signed_divide_with_overflow_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .dividend_high(dividend_high),
		.dividend_low(dividend_low), .divisor(divisor),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .quotient(quotient), .remainder(remainder)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// x86 idiv: sign extend per size, truncating divide, range check on full quotient
	function automatic div_res_t predict_idiv(div_op_t op);
		div_res_t res;
		int unsigned nbits;
		logic signed [63:0] dend;
		logic signed [63:0] dsor;
		logic [63:0] nmag;
		logic [63:0] dmag;
		logic [63:0] qmag;
		logic [63:0] rmag;
		logic [63:0] qv;
		logic [63:0] rv;
		logic [63:0] wmask;
		logic [63:0] lim;
		bit qneg;
		res.st = sdiv_pkg::ST_OK;
		res.q = '0;
		res.r = '0;
		case (op.mode)
			sdiv_pkg::MODE_BYTE: begin
				nbits = 8;
				dend = {{48{op.lo[15]}}, op.lo[15:0]};
				dsor = {{56{op.dv[7]}}, op.dv[7:0]};
			end
			sdiv_pkg::MODE_WORD: begin
				nbits = 16;
				dend = {{32{op.hi[15]}}, op.hi[15:0], op.lo[15:0]};
				dsor = {{48{op.dv[15]}}, op.dv[15:0]};
			end
			default: begin
				nbits = 32;
				dend = {op.hi, op.lo};
				dsor = {{32{op.dv[31]}}, op.dv};
			end
		endcase
		wmask = (64'd1 << nbits) - 64'd1;
		if (dsor == 0) begin
			res.st = sdiv_pkg::ST_DIVZERO;
			return res;
		end
		nmag = dend[63] ? -dend : dend;
		dmag = dsor[63] ? -dsor : dsor;
		qmag = nmag / dmag;
		rmag = nmag % dmag;
		qneg = dend[63] != dsor[63];
		lim = 64'd1 << (nbits - 1);
		if (qneg ? (qmag > lim) : (qmag >= lim)) begin
			res.st = sdiv_pkg::ST_OVERFLOW;
			return res;
		end
		qv = qneg ? -qmag : qmag;
		rv = dend[63] ? -rmag : rmag;
		res.q = qv[31:0] & wmask[31:0];
		res.r = rv[31:0] & wmask[31:0];
		return res;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return $urandom_range(0, 255);
			3: return -$urandom_range(1, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(logic [1:0] m, logic [31:0] h, logic [31:0] l, logic [31:0] d);
		div_op_t op;
		op.mode = m;
		op.hi = h;
		op.lo = l;
		op.dv = d;
		pending_ops.push_back(op);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			dividend_high <= '0;
			dividend_low <= '0;
			divisor <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				div_op_t acc;
				acc.mode = mode;
				acc.hi = dividend_high;
				acc.lo = dividend_low;
				acc.dv = divisor;
				expected_results.push_back(predict_idiv(acc));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (drain_req && (expected_results.size() > 0 || (in_valid && in_ready))) begin
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					div_op_t nxt;
					nxt = pending_ops.pop_front();
					in_valid <= 1'b1;
					mode <= nxt.mode;
					dividend_high <= nxt.hi;
					dividend_low <= nxt.lo;
					divisor <= nxt.dv;
					send_gap <= rand_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word st=%0d q=%h r=%h", $time, status,
						quotient, remainder);
					errors++;
				end else begin
					div_res_t exp_res;
					exp_res = expected_results.pop_front();
					if (status !== exp_res.st || quotient !== exp_res.q ||
							remainder !== exp_res.r) begin
						$display("%0t: mismatch expected st=%0d q=%h r=%h actual st=%0d q=%h r=%h",
							$time, exp_res.st, exp_res.q, exp_res.r, status, quotient,
							remainder);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap <= rand_gap();
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: range limits, zero divisors, overflow edges, unused mode and bits
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_7f00, 32'h0);
		push_op(sdiv_pkg::MODE_BYTE, 32'hffffffff, 32'hffff_8000, 32'hff);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_8000, 32'h1);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_ff80, 32'hffff_ff01);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_007f, 32'h01);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_0080, 32'hff);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'hffff_fff9, 32'h02);
		push_op(sdiv_pkg::MODE_BYTE, 32'h0, 32'h0000_7fff, 32'h80);
		push_op(sdiv_pkg::MODE_WORD, 32'h0000_8000, 32'h0, 32'h0001_0000);
		push_op(sdiv_pkg::MODE_WORD, 32'hffff_ffff, 32'hffff_8000, 32'h1);
		push_op(sdiv_pkg::MODE_WORD, 32'h0, 32'h0000_8000, 32'hffff);
		push_op(sdiv_pkg::MODE_WORD, 32'h0000_7fff, 32'hffff_ffff, 32'h8000);
		push_op(sdiv_pkg::MODE_WORD, 32'hffff_8000, 32'h0, 32'hffff);
		push_op(sdiv_pkg::MODE_WORD, 32'h0, 32'h7fff, 32'h1);
		push_op(sdiv_pkg::MODE_DWORD, 32'h0, 32'h8000_0000, 32'hffff_ffff);
		push_op(sdiv_pkg::MODE_DWORD, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
		push_op(sdiv_pkg::MODE_DWORD, 32'h8000_0000, 32'h0, 32'h8000_0000);
		push_op(sdiv_pkg::MODE_DWORD, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
		push_op(sdiv_pkg::MODE_DWORD, 32'h3fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
		push_op(sdiv_pkg::MODE_DWORD, 32'hffff_ffff, 32'hffff_fff9, 32'h2);
		push_op(sdiv_pkg::MODE_DWORD, 32'h1234_5678, 32'h9abc_def0, 32'h0);
		push_op(sdiv_pkg::MODE_DWORD_ALT, 32'hffff_ffff, 32'h1, 32'hffff_fffd);
		push_op(sdiv_pkg::MODE_DWORD_ALT, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
		wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);

		// receiver holds off long while sender keeps offering words
		for (int i = 0; i < 1000; i++) begin
			logic [1:0] m;
			logic [31:0] h;
			logic [31:0] l;
			logic [31:0] d;
			m = 2'($urandom_range(0, 3));
			l = rand_word();
			d = rand_word();
			// mostly keep the upper half small so quotients fit
			case ($urandom_range(0, 3))
				0: h = rand_word();
				1: h = {32{l[31]}};
				default: h = d[31] ? -($urandom % (d == 0 ? 1 : -d)) : ($urandom % (d == 0 ? 1 : d));
			endcase
			if (m == sdiv_pkg::MODE_WORD && $urandom_range(0, 1))
				h = {16'($urandom), $urandom_range(0, 1) ? 16'hffff : 16'h0};
			push_op(m, h, l, d);
			if (i == 0)
				hold_off <= 300;
		end
		wait (pending_ops.size() == 0);

		// sender waits for every result, then more random traffic
		drain_req = 1;
		wait (!in_valid && expected_results.size() == 0);
		drain_req = 0;
		for (int i = 0; i < 1000; i++)
			push_op(2'($urandom_range(0, 3)), rand_word(), $urandom, rand_word());

		wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/sdiv_pkg.sv
src/sdiv_pre.sv
src/sdiv_step.sv
src/sdiv_post.sv
src/signed_divide_with_overflow_unit.sv
src/sdiv_checker.sv
sim/signed_divide_with_overflow_unit_tb.sv
